[hdl/mrtu_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame receiver.
// Depends on nothing; every other file in hdl refers to it by scoped names.

package mrtu_pkg;

  localparam int unsigned CFG_W = 8;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_HIGHEST_SLAVE = 2'd0;
  localparam logic [1:0] CFG_BROADCAST_ID  = 2'd1;
  localparam logic [1:0] CFG_BYTE_GAP      = 2'd2;
  localparam logic [1:0] CFG_QUIET         = 2'd3;

  localparam logic [7:0] RST_HIGHEST_SLAVE = 8'd3;
  localparam logic [7:0] RST_BROADCAST_ID  = 8'd0;
  localparam logic [7:0] RST_BYTE_GAP      = 8'd10;
  localparam logic [7:0] RST_QUIET         = 8'd3;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC      = 3'd1,
    ST_NOT_US   = 3'd2,
    ST_ILL_FUNC = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EXC_NONE     = 2'd0,
    EXC_ILL_FUNC = 2'd1,
    EXC_ILL_DATA = 2'd3
  } exc_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_META   = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } mrtu_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [7:0]  data_byte_count;
    logic [8:0]  frame_length;
    logic        send_exception;
    logic [1:0]  exc_code;
  } mrtu_out_t;

  typedef struct packed {
    logic [7:0] highest_slave_id;
    logic [7:0] broadcast_id;
    logic [7:0] byte_gap_ticks;
    logic [7:0] quiet_ticks;
  } mrtu_cfg_t;

  // One byte through the reflected CRC-16, eight shift steps unrolled.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hdl/mrtu_in_reg.sv]
// Input register stage: holds one accepted beat until the framer consumes it.
// Depends on mrtu_pkg for the input payload type.

module mrtu_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mrtu_pkg::mrtu_in_t in_data,
  input  logic             take,
  output logic             vld,
  output mrtu_pkg::mrtu_in_t data
);

  logic               vld_r, vld_nxt;
  mrtu_pkg::mrtu_in_t data_r;

  // The slot frees up in the same cycle that its beat is consumed.
  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule

[hdl/mrtu_framer.sv]
// Frame state machine: header capture, lagging CRC-16, length tracking and verdicts.
// Depends on mrtu_pkg for types, constants and the CRC byte update.

module mrtu_framer #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrtu_pkg::mrtu_cfg_t cfg,
  input  logic                fire,
  input  mrtu_pkg::mrtu_in_t  item,
  output logic                res_vld,
  output mrtu_pkg::mrtu_out_t res
);

  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [7:0]  dbc;
  } hdr_t;

  mrtu_pkg::phase_t phase_r, phase_nxt, eff_phase;
  logic [8:0]       left_r, left_nxt, eff_left, left_dec;
  logic [8:0]       idx_r, idx_nxt, eff_idx;
  logic [15:0]      crc_r, crc_nxt, eff_crc, crc_fed;
  logic [15:0]      last_r, last_nxt, eff_last;
  hdr_t             hdr_r, hdr_nxt, eff_hdr;
  logic [7:0]       idle_r, idle_nxt, idle_inc;
  logic             disc_r, disc_nxt;
  logic             start;
  logic [8:0]       due;
  logic             crc_good;
  mrtu_pkg::status_t st;
  logic             send;
  mrtu_pkg::exc_t   exc;

  // A byte arriving while idle opens a fresh frame.
  assign start     = (phase_r == mrtu_pkg::PH_IDLE);
  assign eff_phase = start ? mrtu_pkg::PH_HEADER : phase_r;
  assign eff_left  = start ? 9'd2 : left_r;
  assign eff_idx   = start ? 9'd0 : idx_r;
  assign eff_crc   = start ? mrtu_pkg::CRC_INIT : crc_r;
  assign eff_last  = start ? 16'h0000 : last_r;
  assign eff_hdr   = start ? hdr_t'('0) : hdr_r;
  assign crc_fed   = mrtu_pkg::crc16_feed(eff_crc, eff_last[15:8]);
  assign idle_inc  = (idle_r != 8'hFF) ? idle_r + 8'd1 : idle_r;
  assign left_dec  = (eff_left != 9'd0) ? eff_left - 9'd1 : 9'd0;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    last_nxt  = last_r;
    hdr_nxt   = hdr_r;
    idle_nxt  = idle_r;
    disc_nxt  = disc_r;
    res_vld   = 1'b0;
    st        = mrtu_pkg::ST_OK;
    send      = 1'b0;
    exc       = mrtu_pkg::EXC_NONE;
    due       = 9'd2;
    crc_good  = 1'b0;
    if (fire) begin
      if (item.mode == mrtu_pkg::MODE_TICK) begin
        idle_nxt = idle_inc;
        if (disc_r) begin
          if (idle_inc >= cfg.quiet_ticks) begin
            disc_nxt  = 1'b0;
            idle_nxt  = 8'd0;
            phase_nxt = mrtu_pkg::PH_IDLE;
            left_nxt  = 9'd0;
          end
        end else if (phase_r != mrtu_pkg::PH_IDLE && idle_inc >= cfg.byte_gap_ticks) begin
          res_vld   = 1'b1;
          st        = mrtu_pkg::ST_TIMEOUT;
          idle_nxt  = 8'd0;
          phase_nxt = mrtu_pkg::PH_IDLE;
          left_nxt  = 9'd0;
        end
      end else begin
        idle_nxt = 8'd0;
        if (!disc_r) begin
          // The CRC trails by two bytes so the CRC field itself is never folded in.
          crc_nxt  = (eff_idx >= 9'd2) ? crc_fed : eff_crc;
          last_nxt = {eff_last[7:0], item.rx_byte};
          hdr_nxt  = eff_hdr;
          if (eff_phase != mrtu_pkg::PH_DATA) begin
            unique case (eff_idx)
              9'd0: hdr_nxt.slave     = item.rx_byte;
              9'd1: hdr_nxt.func      = item.rx_byte;
              9'd2: hdr_nxt.addr[15:8] = item.rx_byte;
              9'd3: hdr_nxt.addr[7:0]  = item.rx_byte;
              9'd4: hdr_nxt.cnt[15:8]  = item.rx_byte;
              9'd5: hdr_nxt.cnt[7:0]   = item.rx_byte;
              9'd6: hdr_nxt.dbc       = item.rx_byte;
              default: ;
            endcase
          end
          idx_nxt   = eff_idx + 9'd1;
          left_nxt  = left_dec;
          phase_nxt = eff_phase;
          if (left_dec == 9'd0) begin
            unique case (eff_phase)
              mrtu_pkg::PH_HEADER: begin
                if (hdr_nxt.slave > cfg.highest_slave_id &&
                    hdr_nxt.slave != cfg.broadcast_id) begin
                  res_vld   = 1'b1;
                  st        = mrtu_pkg::ST_NOT_US;
                  phase_nxt = mrtu_pkg::PH_IDLE;
                  disc_nxt  = 1'b1;
                end else if (hdr_nxt.func == mrtu_pkg::FC_READ_HOLDING) begin
                  left_nxt  = 9'd4;
                  phase_nxt = mrtu_pkg::PH_META;
                end else if (hdr_nxt.func == mrtu_pkg::FC_WRITE_MULTI) begin
                  left_nxt  = 9'd5;
                  phase_nxt = mrtu_pkg::PH_META;
                end else begin
                  res_vld   = 1'b1;
                  st        = mrtu_pkg::ST_ILL_FUNC;
                  send      = 1'b1;
                  exc       = mrtu_pkg::EXC_ILL_FUNC;
                  phase_nxt = mrtu_pkg::PH_IDLE;
                  disc_nxt  = 1'b1;
                end
              end
              mrtu_pkg::PH_META: begin
                if (hdr_nxt.func == mrtu_pkg::FC_WRITE_MULTI) begin
                  due = 9'd2 + {1'b0, hdr_nxt.dbc};
                end
                if ({1'b0, idx_nxt} + {1'b0, due} > 10'(MAX_FRAME_BYTES)) begin
                  res_vld   = 1'b1;
                  st        = mrtu_pkg::ST_TOO_LONG;
                  send      = 1'b1;
                  exc       = mrtu_pkg::EXC_ILL_DATA;
                  phase_nxt = mrtu_pkg::PH_IDLE;
                  left_nxt  = 9'd0;
                  disc_nxt  = 1'b1;
                end else begin
                  left_nxt  = due;
                  phase_nxt = mrtu_pkg::PH_DATA;
                end
              end
              mrtu_pkg::PH_DATA: begin
                // The CRC travels low byte first.
                crc_good  = (crc_nxt[7:0] == last_nxt[15:8]) &&
                            (crc_nxt[15:8] == last_nxt[7:0]);
                res_vld   = 1'b1;
                st        = crc_good ? mrtu_pkg::ST_OK : mrtu_pkg::ST_CRC;
                phase_nxt = mrtu_pkg::PH_IDLE;
              end
              mrtu_pkg::PH_IDLE: ;
            endcase
          end
        end
      end
    end
    res.status          = st;
    res.slave_id        = hdr_nxt.slave;
    res.function_code   = hdr_nxt.func;
    res.start_address   = hdr_nxt.addr;
    res.register_count  = hdr_nxt.cnt;
    res.data_byte_count = hdr_nxt.dbc;
    res.frame_length    = idx_nxt;
    res.send_exception  = send;
    res.exc_code        = exc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mrtu_pkg::PH_IDLE;
      left_r  <= 9'd0;
      idx_r   <= 9'd0;
      crc_r   <= mrtu_pkg::CRC_INIT;
      last_r  <= 16'h0000;
      hdr_r   <= '0;
      idle_r  <= 8'd0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      last_r  <= last_nxt;
      hdr_r   <= hdr_nxt;
      idle_r  <= idle_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // Discarding only ever happens between frames.
  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (phase_r == mrtu_pkg::PH_IDLE))
    else $error("discarding while a frame is open");

  // An open frame always has bytes still due; an idle one has none.
  a_left_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mrtu_pkg::PH_IDLE) == (left_r == 9'd0))
    else $error("bytes_left disagrees with phase");

  // Every verdict closes the frame.
  a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (phase_r == mrtu_pkg::PH_IDLE))
    else $error("frame still open after a verdict");

  // The length check keeps the frame within its limit.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} <= 10'(MAX_FRAME_BYTES))
    else $error("frame longer than the limit");

endmodule

[hdl/modbus_rtu_frame_receiver_core.sv]
// Top level of the Modbus RTU frame receiver: configuration registers, result register.
// Depends on mrtu_pkg, mrtu_in_reg and mrtu_framer.
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_ready    mrtu_pkg::mrtu_in_t  (byte or idle tick)
//   out_*     output     out_valid / out_ready  mrtu_pkg::mrtu_out_t (one verdict per frame)
//   cfg_*     input      cfg_we                 cfg_index selects, cfg_wdata is the value
//
// One beat is accepted every cycle while the result side keeps up; a verdict is
// registered twice on its way out: the beat is held in the input register, the framer
// works from it and loads the verdict into the result register.
// The rate is set by the single pass through the framer, whose CRC update is eight
// unrolled shift steps. Synchronous active-low reset returns the registers to their
// reset values and the framer to idle; no clearing pass follows. While a verdict waits
// in the result register, one more beat is taken into the input register and held there
// until the verdict drains; until then in_ready stays low.

module modbus_rtu_frame_receiver_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrtu_pkg::mrtu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrtu_pkg::mrtu_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [mrtu_pkg::CFG_W-1:0] cfg_wdata
);

  mrtu_pkg::mrtu_cfg_t cfg_r, cfg_nxt;
  logic                item_vld;
  mrtu_pkg::mrtu_in_t  item;
  logic                fire;
  logic                res_vld;
  mrtu_pkg::mrtu_out_t res;
  logic                out_valid_r, out_valid_nxt;
  mrtu_pkg::mrtu_out_t out_data_r;

  // Configuration registers; a write lands at every edge where cfg_we is high.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mrtu_pkg::CFG_HIGHEST_SLAVE: cfg_nxt.highest_slave_id = cfg_wdata;
        mrtu_pkg::CFG_BROADCAST_ID:  cfg_nxt.broadcast_id     = cfg_wdata;
        mrtu_pkg::CFG_BYTE_GAP:      cfg_nxt.byte_gap_ticks   = cfg_wdata;
        mrtu_pkg::CFG_QUIET:         cfg_nxt.quiet_ticks      = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.highest_slave_id <= mrtu_pkg::RST_HIGHEST_SLAVE;
      cfg_r.broadcast_id     <= mrtu_pkg::RST_BROADCAST_ID;
      cfg_r.byte_gap_ticks   <= mrtu_pkg::RST_BYTE_GAP;
      cfg_r.quiet_ticks      <= mrtu_pkg::RST_QUIET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrtu_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (fire),
    .vld      (item_vld),
    .data     (item)
  );

  // A held beat is processed whenever the result register has room for a verdict,
  // that is when it is empty or being drained in this cycle.
  assign fire = item_vld && (!out_valid_r || out_ready);

  mrtu_framer #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .fire    (fire),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register decouples the framer from a stalled consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/mrtu_verdict_checker.sv]
// Verdict checker for the Modbus RTU frame receiver: mirrors the framer beat by beat.
// Depends on mrtu_pkg; watches the in_*, out_* and cfg_* ports of the block.

module mrtu_verdict_checker #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  mrtu_pkg::mrtu_in_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  mrtu_pkg::mrtu_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mrtu_pkg::CFG_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         pending
);

  import mrtu_pkg::*;

  // Register copies.
  logic [7:0] slave_hi, bcast_id, gap_limit, quiet_limit;

  // Framer copy.
  phase_t      ph;
  logic [8:0]  left, idx;
  logic [15:0] crc, tail;
  logic [7:0]  hdr_slave, hdr_fc, hdr_dbc, idle_cnt;
  logic [15:0] hdr_addr, hdr_count;
  logic        dropping;

  mrtu_out_t expected_verdicts[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic post_verdict(input status_t st, input logic send, input exc_t code);
    mrtu_out_t v;
    v.status          = st;
    v.slave_id        = hdr_slave;
    v.function_code   = hdr_fc;
    v.start_address   = hdr_addr;
    v.register_count  = hdr_count;
    v.data_byte_count = hdr_dbc;
    v.frame_length    = idx;
    v.send_exception  = send;
    v.exc_code        = code;
    expected_verdicts.push_back(v);
  endtask

  task automatic enter_idle(input logic discard);
    ph       = PH_IDLE;
    left     = '0;
    idle_cnt = '0;
    dropping = discard;
  endtask

  // Advances the framer copy by one accepted beat and queues any verdict.
  task automatic advance_framer(input mrtu_in_t beat);
    logic [7:0] b;
    int due;
    b = beat.rx_byte;
    if (beat.mode == MODE_TICK) begin
      if (idle_cnt != 8'hFF) idle_cnt++;
      if (dropping) begin
        if (idle_cnt >= quiet_limit) enter_idle(1'b0);
      end else if (ph != PH_IDLE && idle_cnt >= gap_limit) begin
        post_verdict(ST_TIMEOUT, 1'b0, EXC_NONE);
        enter_idle(1'b0);
      end
      return;
    end

    idle_cnt = '0;
    if (dropping) return;

    if (ph == PH_IDLE) begin
      idx       = '0;
      crc       = CRC_INIT;
      tail      = '0;
      hdr_slave = '0;
      hdr_fc    = '0;
      hdr_addr  = '0;
      hdr_count = '0;
      hdr_dbc   = '0;
      ph        = PH_HEADER;
      left      = 9'd2;
    end

    // The CRC runs two bytes behind, so the CRC field itself is never folded in.
    if (idx >= 9'd2) crc = crc_byte(crc, tail[15:8]);
    tail = {tail[7:0], b};

    if (ph != PH_DATA) begin
      case (idx)
        9'd0: hdr_slave = b;
        9'd1: hdr_fc = b;
        9'd2: hdr_addr[15:8] = b;
        9'd3: hdr_addr[7:0] = b;
        9'd4: hdr_count[15:8] = b;
        9'd5: hdr_count[7:0] = b;
        9'd6: hdr_dbc = b;
        default: ;
      endcase
    end

    idx = idx + 9'd1;
    if (left != 0) left--;
    if (left != 0) return;

    case (ph)
      PH_HEADER: begin
        if (hdr_slave > slave_hi && hdr_slave != bcast_id) begin
          post_verdict(ST_NOT_US, 1'b0, EXC_NONE);
          enter_idle(1'b1);
        end else if (hdr_fc == FC_READ_HOLDING) begin
          left = 9'd4;
          ph   = PH_META;
        end else if (hdr_fc == FC_WRITE_MULTI) begin
          left = 9'd5;
          ph   = PH_META;
        end else begin
          post_verdict(ST_ILL_FUNC, 1'b1, EXC_ILL_FUNC);
          enter_idle(1'b1);
        end
      end
      PH_META: begin
        due = 2;
        if (hdr_fc == FC_WRITE_MULTI) due += hdr_dbc;
        if (int'(idx) + due > MAX_FRAME_BYTES) begin
          post_verdict(ST_TOO_LONG, 1'b1, EXC_ILL_DATA);
          enter_idle(1'b1);
        end else begin
          left = due[8:0];
          ph   = PH_DATA;
        end
      end
      default: begin
        if (crc[7:0] == tail[15:8] && crc[15:8] == tail[7:0]) begin
          post_verdict(ST_OK, 1'b0, EXC_NONE);
        end else begin
          post_verdict(ST_CRC, 1'b0, EXC_NONE);
        end
        enter_idle(1'b0);
      end
    endcase
  endtask

  always @(posedge clk) begin
    mrtu_out_t want;
    if (!rst_n) begin
      slave_hi    = RST_HIGHEST_SLAVE;
      bcast_id    = RST_BROADCAST_ID;
      gap_limit   = RST_BYTE_GAP;
      quiet_limit = RST_QUIET;
      idx         = '0;
      crc         = CRC_INIT;
      tail        = '0;
      hdr_slave   = '0;
      hdr_fc      = '0;
      hdr_addr    = '0;
      hdr_count   = '0;
      hdr_dbc     = '0;
      enter_idle(1'b0);
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HIGHEST_SLAVE: slave_hi = cfg_wdata;
          CFG_BROADCAST_ID:  bcast_id = cfg_wdata;
          CFG_BYTE_GAP:      gap_limit = cfg_wdata;
          CFG_QUIET:         quiet_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict %h", out_data));
        end else begin
          want = expected_verdicts.pop_front();
          check_field("status", out_data.status, want.status);
          check_field("slave_id", out_data.slave_id, want.slave_id);
          check_field("function_code", out_data.function_code, want.function_code);
          check_field("start_address", out_data.start_address, want.start_address);
          check_field("register_count", out_data.register_count, want.register_count);
          check_field("data_byte_count", out_data.data_byte_count, want.data_byte_count);
          check_field("frame_length", out_data.frame_length, want.frame_length);
          check_field("send_exception", out_data.send_exception, want.send_exception);
          check_field("exc_code", out_data.exc_code, want.exc_code);
        end
      end
      if (in_valid && in_ready) advance_framer(in_data);
    end
    pending = expected_verdicts.size();
  end

endmodule

[tb/modbus_rtu_frame_receiver_core_test.sv]
// Testbench top for the Modbus RTU frame receiver: clock, reset, stimulus and verdict.
// Depends on mrtu_pkg, modbus_rtu_frame_receiver_core and mrtu_verdict_checker.

module modbus_rtu_frame_receiver_core_test;

  import mrtu_pkg::*;

  // A verdict leaves the block through the input and result registers; the settle
  // margin also covers a beat that sits in the input register and yields nothing.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  mrtu_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  mrtu_out_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_HIGHEST_SLAVE;
  logic [7:0] cfg_wdata = '0;

  int mismatches;
  int pending;

  modbus_rtu_frame_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mrtu_verdict_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The run is bounded no matter what the block does with its handshakes.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Beats waiting to go out, and how many have been queued and taken so far.
  // The taken count and the accept flag move at the rising edge; the driver and
  // the main sequence only look at them at the falling edge.
  mrtu_in_t beat_q[$];
  int       beats_queued = 0;
  int       beats_taken = 0;
  logic     in_took = 1'b0;

  always @(posedge clk) begin
    in_took = in_valid && in_ready;
    if (in_took) beats_taken++;
  end

  // Sender: bursts of random length separated by random gaps. About a third of
  // the gaps are empty, which gives long stretches of back-to-back beats. A beat
  // stays on the port unchanged until the block takes it.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (gap_left != 0 || beat_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_data  <= beat_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: it switches between styles of stalling every so often. Always
  // ready, coin flips, a sparse fixed rhythm, and one-in-eight acceptance that
  // leaves a verdict waiting in the result register.
  int stall_style = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick % 3) == 0;
      default: out_ready <= (stall_tick % 8) == 7;
    endcase
  end

  // The settings in force, kept here so that generated frames can aim at them.
  logic [7:0] slave_hi = RST_HIGHEST_SLAVE;
  logic [7:0] bcast_id = RST_BROADCAST_ID;
  logic [7:0] gap_ticks = RST_BYTE_GAP;
  logic [7:0] quiet_len = RST_QUIET;

  // Frame under construction.
  logic [7:0] frame_bytes[$];

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task push_beat(input logic mode, input logic [7:0] b);
    mrtu_in_t beat;
    beat.mode = mode;
    beat.rx_byte = b;
    beat_q.push_back(beat);
    beats_queued++;
  endtask

  task push_ticks(input int n);
    repeat (n) push_beat(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Enough quiet line to end discarding or to time out a half-built frame,
  // whichever the block happens to be in.
  task resync;
    push_ticks((gap_ticks > quiet_len) ? gap_ticks : quiet_len);
  endtask

  // Builds a request with a correct CRC, then optionally flips one bit past
  // the header start and optionally keeps only the first keep bytes. With
  // pauses set, short idle runs below the byte gap fall between bytes.
  task send_request(input logic [7:0] slave, input logic [7:0] fc,
                    input logic [15:0] addr, input logic [15:0] count,
                    input logic [7:0] dbc, input int keep,
                    input bit corrupt, input bit pauses);
    logic [15:0] crc;
    int pos;
    int n;
    frame_bytes.delete();
    frame_bytes.push_back(slave);
    frame_bytes.push_back(fc);
    if (fc == FC_READ_HOLDING || fc == FC_WRITE_MULTI) begin
      frame_bytes.push_back(addr[15:8]);
      frame_bytes.push_back(addr[7:0]);
      frame_bytes.push_back(count[15:8]);
      frame_bytes.push_back(count[7:0]);
      if (fc == FC_WRITE_MULTI) begin
        frame_bytes.push_back(dbc);
        repeat (dbc) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = crc_update(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(2, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (keep > 0) begin
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[i]) begin
      if (pauses && gap_ticks > 1 && i > 0 && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, (gap_ticks > 20) ? 20 : gap_ticks - 1);
        push_ticks(n);
      end
      push_beat(MODE_BYTE, frame_bytes[i]);
    end
  endtask

  // Drives a write of one register onto the configuration port. Only called while the
  // block has nothing in flight.
  task put_reg(input logic [1:0] index, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
  endtask

  task apply_settings(input logic [7:0] hi, input logic [7:0] bc,
                      input logic [7:0] gap, input logic [7:0] quiet);
    slave_hi  = hi;
    bcast_id  = bc;
    gap_ticks = gap;
    quiet_len = quiet;
    put_reg(CFG_HIGHEST_SLAVE, hi);
    put_reg(CFG_BROADCAST_ID, bc);
    put_reg(CFG_BYTE_GAP, gap);
    put_reg(CFG_QUIET, quiet);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every beat is taken and every verdict has come back, then lets
  // the pipeline empty out.
  task drain;
    while (beats_taken != beats_queued) @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] answered_slave();
    if ($urandom_range(0, 5) == 0) return bcast_id;
    return 8'($urandom_range(0, slave_hi));
  endfunction

  function automatic logic [7:0] foreign_slave();
    logic [7:0] s;
    s = 8'($urandom_range(slave_hi + 1, 255));
    while (s == bcast_id) s = 8'($urandom_range(slave_hi + 1, 255));
    return s;
  endfunction

  function automatic logic [7:0] bad_function();
    logic [7:0] f;
    f = 8'($urandom_range(0, 255));
    while (f == FC_READ_HOLDING || f == FC_WRITE_MULTI) f = 8'($urandom_range(0, 255));
    return f;
  endfunction

  // Payload sizes stay small; now and then a write goes up to the longest
  // frame that still fits.
  function automatic logic [7:0] payload_size();
    if ($urandom_range(0, 39) == 0) return 8'($urandom_range(0, 247));
    return 8'($urandom_range(0, 10));
  endfunction

  // Short directed sequence with the reset settings: idle tick, field
  // extremes, broadcast with an empty payload, each error verdict, a byte that
  // lands during discarding, and a frame left to time out.
  task directed_frames;
    push_ticks(1);
    send_request(8'd3, FC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 8'd0, 0, 1'b0, 1'b0);
    send_request(8'd0, FC_WRITE_MULTI, 16'h0000, 16'h0000, 8'd0, 0, 1'b0, 1'b0);
    send_request(8'd1, FC_WRITE_MULTI, 16'hA5C3, 16'h0001, 8'd2, 0, 1'b0, 1'b0);
    send_request(8'd2, FC_READ_HOLDING, 16'h00FF, 16'hFF00, 8'd0, 0, 1'b1, 1'b0);
    send_request(8'hFF, FC_READ_HOLDING, 16'h0000, 16'h0000, 8'd0, 3, 1'b0, 1'b0);
    push_ticks(quiet_len - 1);
    push_beat(MODE_BYTE, 8'h5A);
    push_ticks(quiet_len);
    send_request(8'd1, 8'h80, 16'h0000, 16'h0000, 8'd0, 2, 1'b0, 1'b0);
    push_ticks(quiet_len);
    send_request(8'd2, FC_WRITE_MULTI, 16'h0000, 16'h0000, 8'hFF, 7, 1'b0, 1'b0);
    push_ticks(quiet_len);
    send_request(8'd3, FC_READ_HOLDING, 16'h1234, 16'h5678, 8'd0, 3, 1'b0, 1'b0);
    push_ticks(gap_ticks);
  endtask

  // Almost half are well-formed requests with random content; the rest are corrupted,
  // cut short, misaddressed, unknown or oversized requests and plain noise.
  // Every broken case is followed by enough quiet line to resynchronize.
  // The budget counts every beat queued, idle ticks included.
  task random_traffic(input int budget);
    int start;
    int roll;
    logic [7:0] fc;
    logic [7:0] dbc;
    start = beats_queued;
    while (beats_queued - start < budget) begin
      roll = $urandom_range(0, 99);
      fc = $urandom_range(0, 1) ? FC_WRITE_MULTI : FC_READ_HOLDING;
      dbc = payload_size();
      if (roll < 45) begin
        send_request(answered_slave(), fc, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), dbc, 0, 1'b0, 1'b1);
        push_ticks($urandom_range(0, 2));
      end else if (roll < 55) begin
        send_request(answered_slave(), fc, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), dbc, $urandom_range(1, 7), 1'b0, 1'b0);
        push_ticks(gap_ticks);
      end else if (roll < 65) begin
        send_request(answered_slave(), fc, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), dbc, 0, 1'b1, 1'b0);
        resync();
      end else if (roll < 73) begin
        send_request(foreign_slave(), $urandom_range(0, 1) ? fc : bad_function(),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), dbc,
                     0, 1'b0, 1'b0);
        resync();
      end else if (roll < 81) begin
        send_request(answered_slave(), bad_function(), 16'h0000, 16'h0000, 8'd0,
                     0, 1'b0, 1'b0);
        resync();
      end else if (roll < 85) begin
        send_request(answered_slave(), FC_WRITE_MULTI, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(248, 255)),
                     $urandom_range(7, 11), 1'b0, 1'b0);
        resync();
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 3) != 0) begin
            push_beat(MODE_BYTE, 8'($urandom_range(0, 255)));
          end else begin
            push_ticks($urandom_range(1, 3));
          end
        end
        resync();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_settings(RST_HIGHEST_SLAVE, RST_BROADCAST_ID, RST_BYTE_GAP, RST_QUIET);
    directed_frames();
    drain();

    apply_settings(8'($urandom_range(1, 247)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(1, 40)), 8'($urandom_range(1, 20)));
    random_traffic(PHASE_ITEMS);
    drain();

    // Lowest limits: a single idle tick times out a frame or ends discarding,
    // and the broadcast address sits at the top of the byte range.
    apply_settings(8'd1, 8'd255, 8'd1, 8'd1);
    random_traffic(PHASE_ITEMS);
    drain();

    // Highest limits: every legal address answers and the line must stay quiet
    // for the longest time before a frame is given up.
    apply_settings(8'd247, 8'd0, 8'd255, 8'd255);
    random_traffic(PHASE_ITEMS / 2);
    drain();

    apply_settings(8'd247, 8'd255, 8'd1, 8'd255);
    random_traffic(PHASE_ITEMS / 2);
    drain();

    repeat (2) begin
      apply_settings(8'($urandom_range(1, 247)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 40)), 8'($urandom_range(1, 20)));
      random_traffic(PHASE_ITEMS);
      drain();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mrtu_pkg.sv
hdl/mrtu_in_reg.sv
hdl/mrtu_framer.sv
hdl/modbus_rtu_frame_receiver_core.sv
tb/mrtu_verdict_checker.sv
tb/modbus_rtu_frame_receiver_core_test.sv
